@@ rtl/swtl_pkg.sv @@
`default_nettype none

package swtl_pkg;

  typedef logic [7:0] byte_t;

  // input op codes
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_QUERY = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // result kind codes
  localparam logic KIND_LOAD_ACK = 1'b0;
  localparam logic KIND_QUERY    = 1'b1;

  localparam byte_t CH_NEWLINE = 8'h0a;
  localparam byte_t CH_DIGIT_0 = 8'h30;
  localparam byte_t CH_DIGIT_9 = 8'h39;
  localparam byte_t CH_NUL     = 8'h00;

endpackage

`default_nettype wire

@@ rtl/swtl_ram.sv @@
`default_nettype none

module swtl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/stop_word_table_lookup_unit.sv @@
`default_nettype none

// Stop-word table with binary-search lookup; words stay in load order, so the
// search relies on sorted loads. Words arrive one character per request (op
// load or query, last closes the word); op clear empties the table. A
// character request that does not close a word causes no stall. A closing load
// copies the assembled word into the table memory, one byte per cycle, unless
// the table is full, which is acknowledged with the full flag. A closing query
// whose word starts with a digit is a stop word without a search; otherwise
// each binary-search probe compares bytes up to the first difference or word
// end (up to KEY_LEN), and at most ceil(log2(count + 1)) probes run. The table
// memory and the character buffer each have a single read port and are walked
// one byte per cycle. The table memory needs no clearing pass after reset.
module stop_word_table_lookup_unit
  import swtl_pkg::*;
#(
  parameter int MAX_WORDS = 512,
  parameter int KEY_LEN   = 80
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] in_op,
  input  wire logic [7:0] in_ch,
  input  wire logic       in_last,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            out_kind,
  output logic            out_is_stop,
  output logic [9:0]      out_stored_count,
  output logic            out_table_full
);

  localparam int CW     = $clog2(MAX_WORDS + 1);
  localparam int PW     = $clog2(KEY_LEN + 1);
  localparam int AW     = (KEY_LEN > 1) ? $clog2(KEY_LEN) : 1;
  localparam int TDEPTH = MAX_WORDS * KEY_LEN;
  localparam int TAW    = (TDEPTH > 1) ? $clog2(TDEPTH) : 1;

  localparam logic [TAW-1:0] KEY_LEN_T  = TAW'(KEY_LEN);
  localparam logic [PW-1:0]  KEY_LEN_P  = PW'(KEY_LEN);
  localparam logic [AW-1:0]  LAST_BYTE  = AW'(KEY_LEN - 1);
  localparam logic [CW-1:0]  MAX_WORDS_C = CW'(MAX_WORDS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_COPY  = 3'd1;
  localparam logic [2:0] S_PROBE = 3'd2;
  localparam logic [2:0] S_CMP   = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0]     state_r, state_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic [PW-1:0]  pos_r, pos_nxt;
  logic [PW-1:0]  fill_r, fill_nxt;
  byte_t          first_r, first_nxt;
  logic [CW-1:0]  lo_r, lo_nxt;
  logic [CW-1:0]  hix_r, hix_nxt;    // exclusive upper bound
  logic [CW-1:0]  mid_r, mid_nxt;
  logic [TAW-1:0] base_r, base_nxt;
  logic [PW-1:0]  rd_idx_r, rd_idx_nxt;
  logic           pend_r, pend_nxt;
  logic [AW-1:0]  pend_idx_r, pend_idx_nxt;
  logic           is_query_r, is_query_nxt;
  logic           res_stop_r, res_stop_nxt;
  logic           res_full_r, res_full_nxt;

  logic           out_valid_r, out_valid_nxt;
  logic           out_kind_r, out_kind_nxt;
  logic           out_is_stop_r, out_is_stop_nxt;
  logic [9:0]     out_count_r, out_count_nxt;
  logic           out_full_r, out_full_nxt;

  logic           acc;
  logic           out_free;
  logic           buf_we;
  byte_t          buf_q;
  logic           tbl_we;
  byte_t          tbl_q;
  byte_t          a_byte;
  logic           byte_neq;
  logic           byte_gt;
  logic           key_end;
  logic           issue;
  logic [CW:0]    mid_sum;

  assign in_stall = (state_r != S_IDLE);
  assign acc      = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // buffer bytes past the fill count read as zero
  assign a_byte   = (PW'(pend_idx_r) < fill_r) ? buf_q : CH_NUL;
  assign byte_neq = (a_byte != tbl_q);
  assign byte_gt  = (a_byte > tbl_q);
  assign key_end  = (a_byte == CH_NUL) || (pend_idx_r == LAST_BYTE);
  assign mid_sum  = {1'b0, lo_r} + {1'b0, hix_r} - (CW + 1)'(1);

  swtl_ram #(
    .WIDTH(8),
    .DEPTH(KEY_LEN)
  ) u_buf_ram (
    .clk  (clk),
    .we   (buf_we),
    .waddr(pos_r[AW-1:0]),
    .wdata(in_ch),
    .raddr(rd_idx_r[AW-1:0]),
    .rdata(buf_q)
  );

  swtl_ram #(
    .WIDTH(8),
    .DEPTH(TDEPTH)
  ) u_tbl_ram (
    .clk  (clk),
    .we   (tbl_we),
    .waddr(base_r + TAW'(pend_idx_r)),
    .wdata(a_byte),
    .raddr(base_r + TAW'(rd_idx_r)),
    .rdata(tbl_q)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    fill_nxt      = fill_r;
    first_nxt     = first_r;
    lo_nxt        = lo_r;
    hix_nxt       = hix_r;
    mid_nxt       = mid_r;
    base_nxt      = base_r;
    rd_idx_nxt    = rd_idx_r;
    pend_nxt      = 1'b0;
    pend_idx_nxt  = rd_idx_r[AW-1:0];
    is_query_nxt  = is_query_r;
    res_stop_nxt  = res_stop_r;
    res_full_nxt  = res_full_r;
    buf_we        = 1'b0;
    tbl_we        = 1'b0;
    issue         = 1'b0;

    out_valid_nxt   = out_valid_r && out_stall;
    out_kind_nxt    = out_kind_r;
    out_is_stop_nxt = out_is_stop_r;
    out_count_nxt   = out_count_r;
    out_full_nxt    = out_full_r;

    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          priority if (in_op == OP_CLEAR) begin
            count_nxt = '0;
            pos_nxt   = '0;
            fill_nxt  = '0;
            first_nxt = CH_NUL;
          end else if (in_op == OP_LOAD || in_op == OP_QUERY) begin
            if (pos_r < KEY_LEN_P) begin
              if (in_ch == CH_NEWLINE) begin
                // rest of the word is dropped
                pos_nxt = KEY_LEN_P;
              end else begin
                buf_we   = 1'b1;
                pos_nxt  = pos_r + PW'(1);
                fill_nxt = pos_r + PW'(1);
                if (pos_r == '0) begin
                  first_nxt = in_ch;
                end
              end
            end
            if (in_last) begin
              is_query_nxt = (in_op == OP_QUERY);
              res_full_nxt = 1'b0;
              res_stop_nxt = 1'b0;
              rd_idx_nxt   = '0;
              if (in_op == OP_LOAD) begin
                if (count_r < MAX_WORDS_C) begin
                  base_nxt  = TAW'(count_r) * KEY_LEN_T;
                  state_nxt = S_COPY;
                end else begin
                  res_full_nxt = 1'b1;
                  state_nxt    = S_FIN;
                end
              end else if (first_nxt >= CH_DIGIT_0 && first_nxt <= CH_DIGIT_9) begin
                res_stop_nxt = 1'b1;
                state_nxt    = S_FIN;
              end else begin
                lo_nxt    = '0;
                hix_nxt   = count_r;
                state_nxt = S_PROBE;
              end
            end
          end else begin
            // unused op code: no effect
          end
        end
      end

      S_COPY: begin
        issue = (rd_idx_r < KEY_LEN_P);
        if (pend_r) begin
          tbl_we = 1'b1;
          if (pend_idx_r == LAST_BYTE) begin
            count_nxt = count_r + CW'(1);
            state_nxt = S_FIN;
          end
        end
      end

      S_PROBE: begin
        rd_idx_nxt = '0;
        if (lo_r < hix_r) begin
          mid_nxt   = mid_sum[CW:1];
          base_nxt  = TAW'(mid_sum[CW:1]) * KEY_LEN_T;
          state_nxt = S_CMP;
        end else begin
          res_stop_nxt = 1'b0;
          state_nxt    = S_FIN;
        end
      end

      S_CMP: begin
        issue = (rd_idx_r < KEY_LEN_P) && !(pend_r && (byte_neq || key_end));
        if (pend_r) begin
          if (byte_neq) begin
            if (byte_gt) begin
              lo_nxt = mid_r + CW'(1);
            end else begin
              hix_nxt = mid_r;
            end
            state_nxt = S_PROBE;
          end else if (key_end) begin
            res_stop_nxt = 1'b1;
            state_nxt    = S_FIN;
          end
        end
      end

      S_FIN: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_kind_nxt    = is_query_r ? KIND_QUERY : KIND_LOAD_ACK;
          out_is_stop_nxt = res_stop_r;
          out_count_nxt   = 10'(count_r);
          out_full_nxt    = res_full_r;
          pos_nxt         = '0;
          fill_nxt        = '0;
          first_nxt       = CH_NUL;
          state_nxt       = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (issue) begin
      rd_idx_nxt = rd_idx_r + PW'(1);
      pend_nxt   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pos_r       <= '0;
      fill_r      <= '0;
      first_r     <= CH_NUL;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pos_r       <= pos_nxt;
      fill_r      <= fill_nxt;
      first_r     <= first_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r          <= lo_nxt;
    hix_r         <= hix_nxt;
    mid_r         <= mid_nxt;
    base_r        <= base_nxt;
    rd_idx_r      <= rd_idx_nxt;
    pend_idx_r    <= pend_idx_nxt;
    is_query_r    <= is_query_nxt;
    res_stop_r    <= res_stop_nxt;
    res_full_r    <= res_full_nxt;
    out_kind_r    <= out_kind_nxt;
    out_is_stop_r <= out_is_stop_nxt;
    out_count_r   <= out_count_nxt;
    out_full_r    <= out_full_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_is_stop      = out_is_stop_r;
  assign out_stored_count = out_count_r;
  assign out_table_full   = out_full_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= MAX_WORDS_C)
    else $error("word count above table size");

  a_copy_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COPY) |-> (count_r < MAX_WORDS_C))
    else $error("copy into a full table");

  a_search_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |-> (lo_r <= mid_r && mid_r < hix_r && hix_r <= count_r))
    else $error("probe outside search bounds");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_FIN))
    else $error("result raised outside finish step");

endmodule

`default_nettype wire
